[rtl/complex_fixed_point_alu_core_macros.svh]
// Assertion macros for the complex fixed-point ALU core.
// Included by the top level; needs nothing else.
`ifndef COMPLEX_FIXED_POINT_ALU_CORE_MACROS_SVH
`define COMPLEX_FIXED_POINT_ALU_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CFPA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CFPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/cfpa_pkg.sv]
// Shared types and constants for the complex fixed-point ALU core.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package cfpa_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 12;
   localparam int MAX_EXP_DEF    = 255;

   localparam int ACTION_W = 3;
   localparam int EXP_W    = 8;

   typedef logic [ACTION_W-1:0] action_type;

   localparam action_type ACT_ADD  = 3'd0;
   localparam action_type ACT_SUB  = 3'd1;
   localparam action_type ACT_MUL  = 3'd2;
   localparam action_type ACT_NEG  = 3'd3;
   localparam action_type ACT_CONJ = 3'd4;
   localparam action_type ACT_NORM = 3'd5;
   localparam action_type ACT_POW  = 3'd6;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_LOAD,
      DP_LIN,
      DP_ONE,
      DP_MUL_A,
      DP_MUL_B,
      DP_MUL_C,
      DP_NORM
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      emit;
   } cmd_type;

   typedef struct packed {
      action_type       action;
      logic [EXP_W-1:0] exp_count;
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_MUL_A,
      S_MUL_B,
      S_MUL_C,
      S_NORM,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

[rtl/cfpa_ctrl.sv]
// Sequencer for the complex fixed-point ALU: handshakes, step count, result valid.
// Depends on cfpa_pkg; drives cfpa_dp through cmd_type.
`default_nettype none

module cfpa_ctrl
   import cfpa_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type        state_ff, state_in;
   logic [EXP_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = DP_NOP;
      cmd.emit     = 1'b0;
      req_tready   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = DP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.action) inside
               ACT_MUL, ACT_NORM: begin
                  state_in = S_MUL_A;
               end
               ACT_POW: begin
                  cmd.op = DP_ONE;
                  cnt_in = status.exp_count;
                  state_in = (status.exp_count == '0) ? S_DONE : S_MUL_A;
               end
               default: begin
                  cmd.op   = DP_LIN;
                  state_in = S_DONE;
               end
            endcase
         end
         S_MUL_A: begin
            cmd.op   = DP_MUL_A;
            state_in = (status.action == ACT_NORM) ? S_NORM : S_MUL_B;
         end
         S_MUL_B: begin
            cmd.op   = DP_MUL_B;
            state_in = S_MUL_C;
         end
         S_MUL_C: begin
            cmd.op = DP_MUL_C;
            if (status.action == ACT_POW && cnt_ff > EXP_W'(1)) begin
               cnt_in   = cnt_ff - EXP_W'(1);
               state_in = S_MUL_A;
            end else begin
               state_in = S_DONE;
            end
         end
         S_NORM: begin
            cmd.op   = DP_NORM;
            state_in = S_DONE;
         end
         S_DONE: begin
            // wait for the output register to drain before overwriting it
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

[rtl/cfpa_dp.sv]
// Datapath for the complex fixed-point ALU: operand store, multiplier pair,
// saturating adders and the result register. Depends on cfpa_pkg.
`default_nettype none

module cfpa_dp
   import cfpa_pkg::*;
#(
   parameter  int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter  int FRAC_BITS  = FRAC_BITS_DEF,
   parameter  int MAX_EXP    = MAX_EXP_DEF,
   localparam int REQ_W      = ((4 * DATA_WIDTH + EXP_W + 7) / 8) * 8
)
(
   input  wire logic                   clock,
   input  wire logic [REQ_W-1:0]       req_tdata,
   input  wire action_type             req_tuser,
   input  wire cmd_type                cmd,
   output status_type                  status,
   output logic signed [DATA_WIDTH-1:0] res_re,
   output logic signed [DATA_WIDTH-1:0] res_im,
   output logic                        res_ovf
);

   localparam int DW      = DATA_WIDTH;
   localparam int PW      = 2 * DW;
   localparam int SW      = PW + 1;
   localparam int EXP_TOP = (1 << EXP_W) - 1;
   localparam int EXP_CAP = (MAX_EXP < EXP_TOP) ? MAX_EXP : EXP_TOP;

   localparam logic [DW-1:0] WMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] WMIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [SW-1:0] ONE_WIDE = SW'(1) << FRAC_BITS;

   typedef logic signed [DW-1:0] word_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [SW-1:0] wide_type;

   // returns {flag, value}
   function automatic logic [DW:0] sat_fn(input wide_type x);
      logic [DW:0] r;
      if (x[SW-1:DW-1] == {(SW-DW+1){x[SW-1]}}) begin
         r = {1'b0, x[DW-1:0]};
      end else if (x[SW-1]) begin
         r = {1'b1, WMIN};
      end else begin
         r = {1'b1, WMAX};
      end
      return r;
   endfunction

   function automatic wide_type sx(input word_type w);
      return {{(SW-DW){w[DW-1]}}, w};
   endfunction

   function automatic wide_type sxp(input prod_type p);
      return {p[PW-1], p};
   endfunction

   action_type       action_ff;
   logic [EXP_W-1:0] exp_ff;
   word_type         a_re_ff, a_im_ff, b_re_ff, b_im_ff;
   word_type         acc_re_ff, acc_im_ff, tmp_re_ff;
   prod_type         p0_ff, p1_ff;
   logic             ovf_ff;
   word_type         out_re_ff, out_im_ff;
   logic             out_ovf_ff;

   word_type   x_re, x_im, y_re, y_im;
   word_type   m0_r, m1_r;
   prod_type   prod0, prod1;
   wide_type   lin_re, lin_im;
   wide_type   diff_sh, sum_sh;
   logic [DW:0] sat_lin_re, sat_lin_im, sat_diff, sat_sum, sat_one;
   logic [EXP_W-1:0] req_exp;

   // operand routing: power iterates acc * a, norm uses a * a
   always_comb begin
      case (action_ff)
         ACT_POW: begin
            x_re = acc_re_ff;
            x_im = acc_im_ff;
            y_re = a_re_ff;
            y_im = a_im_ff;
         end
         ACT_NORM: begin
            x_re = a_re_ff;
            x_im = a_im_ff;
            y_re = a_re_ff;
            y_im = a_im_ff;
         end
         default: begin
            x_re = a_re_ff;
            x_im = a_im_ff;
            y_re = b_re_ff;
            y_im = b_im_ff;
         end
      endcase
   end

   // first pass forms re*re and im*im, second pass the cross terms
   assign m0_r  = (cmd.op == DP_MUL_B) ? y_im : y_re;
   assign m1_r  = (cmd.op == DP_MUL_B) ? y_re : y_im;
   assign prod0 = x_re * m0_r;
   assign prod1 = x_im * m1_r;

   assign diff_sh = (sxp(p0_ff) - sxp(p1_ff)) >>> FRAC_BITS;
   assign sum_sh  = (sxp(p0_ff) + sxp(p1_ff)) >>> FRAC_BITS;
   assign sat_diff = sat_fn(diff_sh);
   assign sat_sum  = sat_fn(sum_sh);
   assign sat_one  = sat_fn(ONE_WIDE);

   always_comb begin
      case (action_ff) inside
         ACT_ADD: begin
            lin_re = sx(a_re_ff) + sx(b_re_ff);
            lin_im = sx(a_im_ff) + sx(b_im_ff);
         end
         ACT_SUB: begin
            lin_re = sx(a_re_ff) - sx(b_re_ff);
            lin_im = sx(a_im_ff) - sx(b_im_ff);
         end
         ACT_NEG: begin
            lin_re = -sx(a_re_ff);
            lin_im = -sx(a_im_ff);
         end
         ACT_CONJ: begin
            lin_re = sx(a_re_ff);
            lin_im = -sx(a_im_ff);
         end
         default: begin
            lin_re = '0;
            lin_im = '0;
         end
      endcase
   end

   assign sat_lin_re = sat_fn(lin_re);
   assign sat_lin_im = sat_fn(lin_im);

   assign req_exp = req_tdata[4*DW +: EXP_W];

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         DP_NOP: begin
         end
         DP_LOAD: begin
            action_ff <= req_tuser;
            a_re_ff   <= req_tdata[0*DW +: DW];
            a_im_ff   <= req_tdata[1*DW +: DW];
            b_re_ff   <= req_tdata[2*DW +: DW];
            b_im_ff   <= req_tdata[3*DW +: DW];
            exp_ff    <= (int'(req_exp) > EXP_CAP) ? EXP_W'(EXP_CAP) : req_exp;
            ovf_ff    <= 1'b0;
         end
         DP_LIN: begin
            acc_re_ff <= sat_lin_re[DW-1:0];
            acc_im_ff <= sat_lin_im[DW-1:0];
            ovf_ff    <= sat_lin_re[DW] | sat_lin_im[DW];
         end
         DP_ONE: begin
            acc_re_ff <= sat_one[DW-1:0];
            acc_im_ff <= '0;
            ovf_ff    <= sat_one[DW];
         end
         DP_MUL_A: begin
            p0_ff <= prod0;
            p1_ff <= prod1;
         end
         DP_MUL_B: begin
            tmp_re_ff <= sat_diff[DW-1:0];
            ovf_ff    <= ovf_ff | sat_diff[DW];
            p0_ff     <= prod0;
            p1_ff     <= prod1;
         end
         DP_MUL_C: begin
            acc_re_ff <= tmp_re_ff;
            acc_im_ff <= sat_sum[DW-1:0];
            ovf_ff    <= ovf_ff | sat_sum[DW];
         end
         DP_NORM: begin
            acc_re_ff <= sat_sum[DW-1:0];
            acc_im_ff <= '0;
            ovf_ff    <= ovf_ff | sat_sum[DW];
         end
         default: begin
         end
      endcase

      if (cmd.emit) begin
         out_re_ff  <= acc_re_ff;
         out_im_ff  <= acc_im_ff;
         out_ovf_ff <= ovf_ff;
      end
   end

   assign status.action    = action_ff;
   assign status.exp_count = exp_ff;

   assign res_re  = out_re_ff;
   assign res_im  = out_im_ff;
   assign res_ovf = out_ovf_ff;

endmodule

`default_nettype wire

[rtl/complex_fixed_point_alu_core.sv]
// Add, subtract, negate and conjugate go from decode straight to done; squared
// norm passes MUL_A and NORM, multiply MUL_A, MUL_B and MUL_C, and power repeats
// MUL_A, MUL_B and MUL_C once per exponent step (exponent clamped). One item at a
// time: the next beat is taken only after the result is loaded into the output
// register. Multiply steps share one pair of multipliers. A finished result waits in
// the output register while the next beat is taken. Synchronous active-high reset.
`default_nettype none

`include "complex_fixed_point_alu_core_macros.svh"

module complex_fixed_point_alu_core
   import cfpa_pkg::*;
#(
   parameter  int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter  int FRAC_BITS  = FRAC_BITS_DEF,
   parameter  int MAX_EXP    = MAX_EXP_DEF,
   localparam int REQ_W      = ((4 * DATA_WIDTH + EXP_W + 7) / 8) * 8,
   localparam int RSP_W      = ((2 * DATA_WIDTH + 7) / 8) * 8
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,  // a_re, a_im, b_re, b_im, exponent, pad
   input  wire action_type       req_tuser,  // action
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,  // res_re, res_im, pad
   output logic                  rsp_tuser   // overflow
);

   cmd_type    cmd;
   status_type status;
   logic signed [DATA_WIDTH-1:0] res_re, res_im;

   cfpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cfpa_dp #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .MAX_EXP    (MAX_EXP)
   ) u_dp (
      .clock     (clock),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .res_re    (res_re),
      .res_im    (res_im),
      .res_ovf   (rsp_tuser)
   );

   assign rsp_tdata = RSP_W'({res_im, res_re});

   `CFPA_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_tvalid && req_tready, !req_tready, "took a beat while busy")
   `CFPA_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_tvalid && req_tready, !$rose(rsp_tvalid), "result appeared too early")
   `CFPA_ASSERT_IMPLY(a_emit_free, clock, reset, cmd.emit, !rsp_tvalid || rsp_tready, "result register overwritten")

endmodule

`default_nettype wire
